/* rtl/core/lrms_pkg.sv */
// lrms_pkg: shared types and constants of the laplace residual mean square block
// used by every module under rtl/core, depends on nothing
`default_nettype none

package lrms_pkg;

  localparam int unsigned DefMaxRowCells = 1024;
  localparam int unsigned DataW = 32;
  localparam int unsigned SumW = 64;
  localparam int unsigned OutW = 48;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [10:0] GridWidthRst = 11'd3;
  localparam logic [15:0] GridHeightRst = 16'd3;
  localparam logic [31:0] InvSqRst = 32'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridWidth = 2'd0,
    CfgGridHeight = 2'd1,
    CfgInvDxSquared = 2'd2,
    CfgInvDySquared = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic            sat;
    logic [SumW-1:0] sq;
  } sq_res_t;

endpackage

`default_nettype wire

/* rtl/core/lrms_line_store.sv */
// lrms_line_store: the three row memories (upper pressure, middle pressure, middle rhs)
// synchronous read with registered outputs; depends on lrms_pkg
`default_nettype none

module lrms_line_store #(
  parameter int unsigned MaxRowCells = lrms_pkg::DefMaxRowCells
) (
  input  wire logic                              clk_i,
  input  wire logic                              rd_en_i,
  input  wire logic [$clog2(MaxRowCells)-1:0]    rd_addr_i,
  input  wire logic                              wr_en_i,
  input  wire logic [$clog2(MaxRowCells)-1:0]    wr_addr_i,
  input  wire logic [lrms_pkg::DataW-1:0]        wr_up_i,
  input  wire logic [lrms_pkg::DataW-1:0]        wr_mid_i,
  input  wire logic [lrms_pkg::DataW-1:0]        wr_rhs_i,
  output logic      [lrms_pkg::DataW-1:0]        up_o,
  output logic      [lrms_pkg::DataW-1:0]        mid_o,
  output logic      [lrms_pkg::DataW-1:0]        mid_next_o,
  output logic      [lrms_pkg::DataW-1:0]        rhs_o
);

  localparam int unsigned AddrW = $clog2(MaxRowCells);

  logic [lrms_pkg::DataW-1:0] up_mem [MaxRowCells];
  logic [lrms_pkg::DataW-1:0] mid_mem [MaxRowCells];
  logic [lrms_pkg::DataW-1:0] rhs_mem [MaxRowCells];
  logic [AddrW-1:0]           rd_addr_next;

  assign rd_addr_next = rd_addr_i + AddrW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      up_mem[wr_addr_i] <= wr_up_i;
      mid_mem[wr_addr_i] <= wr_mid_i;
      rhs_mem[wr_addr_i] <= wr_rhs_i;
    end
    if (rd_en_i) begin
      up_o <= up_mem[rd_addr_i];
      mid_o <= mid_mem[rd_addr_i];
      mid_next_o <= mid_mem[rd_addr_next];
      rhs_o <= rhs_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lrms_residual.sv */
// lrms_residual: stencil residual of one cell and its saturated Q48.16 square
// multi-step sequencer with one shared 32x32 multiplier; depends on lrms_pkg
`default_nettype none

module lrms_residual (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [31:0]      left_i,
  input  wire logic signed [31:0]      mid_i,
  input  wire logic signed [31:0]      right_i,
  input  wire logic signed [31:0]      up_i,
  input  wire logic signed [31:0]      down_i,
  input  wire logic signed [31:0]      rhs_i,
  input  wire logic [31:0]             fx_i,
  input  wire logic [31:0]             fy_i,
  output logic                         done_o,
  output lrms_pkg::sq_res_t            res_o
);

  typedef enum logic [9:0] {
    R_IDLE  = 10'b00_0000_0001,
    R_MAG   = 10'b00_0000_0010,
    R_MULX  = 10'b00_0000_0100,
    R_MULY  = 10'b00_0000_1000,
    R_SCALE = 10'b00_0001_0000,
    R_RES   = 10'b00_0010_0000,
    R_RMAG  = 10'b00_0100_0000,
    R_SQ    = 10'b00_1000_0000,
    R_SUM   = 10'b01_0000_0000,
    R_DONE  = 10'b10_0000_0000
  } res_state_e;

  res_state_e          state_q, state_d;
  logic signed [34:0]  dxx_q, dyy_q;
  logic signed [31:0]  rhs_q;
  logic [31:0]         fx_q, fy_q;
  logic [34:0]         mx_q, my_q;
  logic                sgx_q, sgy_q;
  logic [63:0]         px_lo_q, py_lo_q;
  logic [34:0]         px_hi_q, py_hi_q;
  logic signed [51:0]  sx_q, sy_q;
  logic signed [53:0]  r_q;
  logic [19:0]         a_q, b_q;
  logic                sat_q;
  logic [39:0]         aa_q, ab_q, bb_q;
  lrms_pkg::sq_res_t   res_q;

  logic [34:0]         mul_m;
  logic [31:0]         mul_f;
  logic [63:0]         mul_lo;
  logic [34:0]         mul_hi;
  logic [66:0]         full_x, full_y;
  logic [50:0]         mag_x, mag_y;
  logic [52:0]         r_mag;

  assign mul_m = (state_q == R_MULX) ? mx_q : my_q;
  assign mul_f = (state_q == R_MULX) ? fx_q : fy_q;
  assign mul_lo = {32'd0, mul_m[31:0]} * {32'd0, mul_f};
  assign mul_hi = {32'd0, mul_m[34:32]} * {3'd0, mul_f};

  assign full_x = {px_hi_q, 32'd0} + {3'd0, px_lo_q};
  assign full_y = {py_hi_q, 32'd0} + {3'd0, py_lo_q};
  assign mag_x = full_x[66:16];
  assign mag_y = full_y[66:16];
  assign r_mag = r_q[53] ? 53'(-r_q) : 53'(r_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      R_IDLE:  if (start_i) state_d = R_MAG;
      R_MAG:   state_d = R_MULX;
      R_MULX:  state_d = R_MULY;
      R_MULY:  state_d = R_SCALE;
      R_SCALE: state_d = R_RES;
      R_RES:   state_d = R_RMAG;
      R_RMAG:  state_d = R_SQ;
      R_SQ:    state_d = R_SUM;
      R_SUM:   state_d = R_DONE;
      R_DONE:  state_d = R_IDLE;
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == R_IDLE && start_i) begin
      dxx_q <= 35'(left_i) - (35'(mid_i) <<< 1) + 35'(right_i);
      dyy_q <= 35'(up_i) - (35'(mid_i) <<< 1) + 35'(down_i);
      rhs_q <= rhs_i;
      fx_q <= fx_i;
      fy_q <= fy_i;
    end
    if (state_q == R_MAG) begin
      sgx_q <= dxx_q[34];
      sgy_q <= dyy_q[34];
      mx_q <= dxx_q[34] ? 35'(-dxx_q) : 35'(dxx_q);
      my_q <= dyy_q[34] ? 35'(-dyy_q) : 35'(dyy_q);
    end
    if (state_q == R_MULX) begin
      px_lo_q <= mul_lo;
      px_hi_q <= mul_hi;
    end
    if (state_q == R_MULY) begin
      py_lo_q <= mul_lo;
      py_hi_q <= mul_hi;
    end
    if (state_q == R_SCALE) begin
      sx_q <= sgx_q ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
      sy_q <= sgy_q ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
    end
    if (state_q == R_RES) begin
      r_q <= 54'(rhs_q) - 54'(sx_q) - 54'(sy_q);
    end
    if (state_q == R_RMAG) begin
      sat_q <= |r_mag[52:40];
      a_q <= r_mag[39:20];
      b_q <= r_mag[19:0];
    end
    if (state_q == R_SQ) begin
      aa_q <= {20'd0, a_q} * {20'd0, a_q};
      ab_q <= {20'd0, a_q} * {20'd0, b_q};
      bb_q <= {20'd0, b_q} * {20'd0, b_q};
    end
    if (state_q == R_SUM) begin
      res_q.sat <= sat_q;
      res_q.sq <= sat_q ? {lrms_pkg::SumW{1'b1}}
                        : {aa_q, 24'd0} + {19'd0, ab_q, 5'd0} + {40'd0, bb_q[39:16]};
    end
  end

  assign done_o = (state_q == R_DONE);
  assign res_o = res_q;

endmodule

`default_nettype wire

/* rtl/core/lrms_divider.sv */
// lrms_divider: restoring divider, one quotient bit per cycle, for the mean
// depends on lrms_pkg
`default_nettype none

module lrms_divider #(
  parameter int unsigned DivW = 29
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [lrms_pkg::SumW-1:0] dividend_i,
  input  wire logic [DivW-1:0]           divisor_i,
  output logic                           done_o,
  output logic [lrms_pkg::SumW-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(lrms_pkg::SumW);

  logic                      busy_q;
  logic                      done_q;
  logic [CntW-1:0]           cnt_q;
  logic [DivW-1:0]           div_q;
  logic [DivW-1:0]           rem_q;
  logic [lrms_pkg::SumW-1:0] quot_q;
  logic [DivW:0]             shifted;
  logic                      fits;

  assign shifted = {rem_q, quot_q[lrms_pkg::SumW-1]};
  assign fits = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CntW'(lrms_pkg::SumW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(lrms_pkg::SumW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? DivW'(shifted - {1'b0, div_q}) : DivW'(shifted);
      quot_q <= {quot_q[lrms_pkg::SumW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* rtl/core/laplace_residual_mean_square.sv */
// laplace_residual_mean_square: top level, control, counters, sum and output register
// depends on lrms_pkg, lrms_line_store, lrms_residual, lrms_divider
//
// usage: pressure and rhs cells enter in raster order on the in channel
// (in_valid_i / in_stall_o), one cell per transfer. configuration is written
// through cfg_we_i / cfg_index_i / cfg_data_i while the block is idle.
// one result per grid leaves on the out channel (out_valid_o / out_stall_i)
// after the last cell: the mean square residual over the inner cells and an
// overflow flag.
// timing: a boundary cell takes a row memory read, then a write back; an inner
// cell also waits on the residual sequencer with its shared multiplier; the
// last cell of a grid adds the bit-serial 64-bit divider, then the load of the
// output register. reset clears counters, sum, flags and the output valid and
// loads the reset configuration; the row memories are not cleared, every entry
// that feeds a residual is written before it is used. a stalled result holds in
// the output register while the next grid streams in; the input is held while a
// cell is processed and while a second result waits on a full output register.
`default_nettype none

module laplace_residual_mean_square #(
  parameter int unsigned MaxRowCells = lrms_pkg::DefMaxRowCells
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lrms_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [31:0]                       cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [31:0]                pressure_value_i,
  input  wire logic signed [31:0]                rhs_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [lrms_pkg::OutW-1:0]              mean_square_residual_o,
  output logic                                   overflow_seen_o
);

  localparam int unsigned AddrW = $clog2(MaxRowCells);
  localparam int unsigned CntW = AddrW + 1;
  localparam int unsigned DivW = CntW + 16;

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_WB   = 5'b00010,
    T_CALC = 5'b00100,
    T_DIV  = 5'b01000,
    T_OUT  = 5'b10000
  } top_state_e;

  top_state_e                 state_q;
  logic [10:0]                grid_width_q;
  logic [15:0]                grid_height_q;
  logic [31:0]                inv_dx_q, inv_dy_q;
  logic [AddrW-1:0]           col_q;
  logic [15:0]                row_q;
  logic [lrms_pkg::SumW-1:0]  sum_q;
  logic                       flag_q;
  logic                       flag_hold_q;
  logic signed [31:0]         p_q, q_q, left_q;
  logic                       out_valid_q;
  logic [lrms_pkg::OutW-1:0]  mean_q;
  logic                       ovf_q;

  logic                       accept;
  logic [CntW-1:0]            w_eff;
  logic [15:0]                h_eff;
  logic [CntW-1:0]            col_next;
  logic                       row_end;
  logic                       grid_end;
  logic                       inner;
  logic [DivW-1:0]            n_cells;
  logic [31:0]                up_rd, mid_rd, mid_next_rd, rhs_rd;
  logic                       res_done;
  lrms_pkg::sq_res_t          res;
  logic                       div_start;
  logic                       div_done;
  logic [lrms_pkg::SumW-1:0]  quot;
  logic                       out_free;
  logic                       quot_big;
  logic                       res_start;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != T_IDLE);

  always_comb begin
    if (grid_width_q < 11'd3) begin
      w_eff = CntW'(3);
    end else if (32'(grid_width_q) > 32'(MaxRowCells)) begin
      w_eff = CntW'(MaxRowCells);
    end else begin
      w_eff = CntW'(grid_width_q);
    end
    h_eff = (grid_height_q < 16'd3) ? 16'd3 : grid_height_q;
  end

  assign col_next = CntW'(col_q) + CntW'(1);
  assign row_end = col_next >= w_eff;
  assign grid_end = row_end && (17'(row_q) + 17'd1 >= 17'(h_eff));
  assign inner = (row_q >= 16'd2) && (row_q < h_eff) && (col_q != '0) && !row_end;
  assign n_cells = DivW'(w_eff - CntW'(2)) * DivW'(h_eff - 16'd2);

  assign res_start = (state_q == T_WB) && inner;
  assign div_start = (state_q == T_WB) && grid_end;
  assign out_free = !out_valid_q || !out_stall_i;
  assign quot_big = |quot[lrms_pkg::SumW-1:lrms_pkg::OutW];

  lrms_line_store #(
    .MaxRowCells(MaxRowCells)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .wr_en_i   (state_q == T_WB),
    .wr_addr_i (col_q),
    .wr_up_i   (mid_rd),
    .wr_mid_i  (p_q),
    .wr_rhs_i  (q_q),
    .up_o      (up_rd),
    .mid_o     (mid_rd),
    .mid_next_o(mid_next_rd),
    .rhs_o     (rhs_rd)
  );

  lrms_residual u_residual (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(res_start),
    .left_i (left_q),
    .mid_i  (mid_rd),
    .right_i(mid_next_rd),
    .up_i   (up_rd),
    .down_i (p_q),
    .rhs_i  (rhs_rd),
    .fx_i   (inv_dx_q),
    .fy_i   (inv_dy_q),
    .done_o (res_done),
    .res_o  (res)
  );

  lrms_divider #(
    .DivW(DivW)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (n_cells),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= lrms_pkg::GridWidthRst;
      grid_height_q <= lrms_pkg::GridHeightRst;
      inv_dx_q <= lrms_pkg::InvSqRst;
      inv_dy_q <= lrms_pkg::InvSqRst;
    end else if (cfg_we_i) begin
      unique case (lrms_pkg::cfg_reg_e'(cfg_index_i))
        lrms_pkg::CfgGridWidth:    grid_width_q <= cfg_data_i[10:0];
        lrms_pkg::CfgGridHeight:   grid_height_q <= cfg_data_i[15:0];
        lrms_pkg::CfgInvDxSquared: inv_dx_q <= cfg_data_i;
        lrms_pkg::CfgInvDySquared: inv_dy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      col_q <= '0;
      row_q <= '0;
      sum_q <= '0;
      flag_q <= 1'b0;
      flag_hold_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == T_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        T_IDLE: begin
          if (accept) state_q <= T_WB;
        end
        T_WB: begin
          if (row_end) begin
            col_q <= '0;
            row_q <= grid_end ? 16'd0 : row_q + 16'd1;
          end else begin
            col_q <= AddrW'(col_next);
          end
          if (inner) begin
            state_q <= T_CALC;
          end else if (grid_end) begin
            flag_hold_q <= flag_q;
            sum_q <= '0;
            flag_q <= 1'b0;
            state_q <= T_DIV;
          end else begin
            state_q <= T_IDLE;
          end
        end
        T_CALC: begin
          if (res_done) begin
            if (res.sq > ~sum_q) begin
              sum_q <= {lrms_pkg::SumW{1'b1}};
              flag_q <= 1'b1;
            end else begin
              sum_q <= sum_q + res.sq;
              flag_q <= flag_q | res.sat;
            end
            state_q <= T_IDLE;
          end
        end
        T_DIV: begin
          if (div_done) state_q <= T_OUT;
        end
        T_OUT: begin
          if (out_free) state_q <= T_IDLE;
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q <= pressure_value_i;
      q_q <= rhs_value_i;
    end
    if (state_q == T_WB) begin
      left_q <= mid_rd;
    end
    if (state_q == T_OUT && out_free) begin
      mean_q <= quot_big ? {lrms_pkg::OutW{1'b1}} : quot[lrms_pkg::OutW-1:0];
      ovf_q <= flag_hold_q | quot_big;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_square_residual_o = mean_q;
  assign overflow_seen_o = ovf_q;

endmodule

`default_nettype wire

/* tb/sv/lrms_checker.sv */
// lrms_checker: watches the cell and result channels, predicts the mean square residual
// of each grid and compares it with what the block delivers; depends on lrms_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrms_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lrms_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_stall_i,
  input  wire logic signed [31:0]           pressure_value_i,
  input  wire logic signed [31:0]           rhs_value_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_stall_i,
  input  wire logic [lrms_pkg::OutW-1:0]    mean_square_residual_i,
  input  wire logic                         overflow_seen_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import lrms_pkg::*;

  localparam int unsigned RowCells = DefMaxRowCells;
  localparam logic [63:0] AllOnes = '1;
  localparam logic [63:0] OutMax = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [OutW-1:0] mean;
    logic            ovf;
  } grid_result_t;

  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [31:0] inv_dx_q, inv_dy_q;
  logic signed [63:0] upper_row [RowCells];
  logic signed [63:0] middle_row [RowCells];
  logic signed [63:0] middle_rhs [RowCells];
  logic signed [63:0] left_mid;
  logic [63:0] square_sum;
  int unsigned col_cnt, row_cnt;
  logic sat_flag;
  grid_result_t grid_results[$];

  assign pending_o = grid_results.size();

  function automatic logic signed [63:0] scale_q16(logic signed [63:0] d, logic [31:0] f);
    logic [63:0] m, r;
    m = d < 0 ? -d : d;
    r = m * f[31:16] + ((m * f[15:0]) >> 16);
    return d < 0 ? -$signed(r) : $signed(r);
  endfunction

  task automatic add_cell(logic signed [63:0] p, logic signed [63:0] q);
    int unsigned w, h, c, n;
    logic signed [63:0] mid, dxx, dyy, lap, res;
    logic [63:0] m, sq, mean;
    logic ovf;
    grid_result_t gr;
    w = width_q < 3 ? 3 : (width_q > RowCells ? RowCells : width_q);
    h = height_q < 3 ? 3 : height_q;
    c = col_cnt >= RowCells ? RowCells - 1 : col_cnt;
    mid = middle_row[c];
    if (row_cnt >= 2 && row_cnt < h && c >= 1 && c + 1 < w) begin
      dxx = left_mid - 2 * mid + middle_row[c+1];
      dyy = upper_row[c] - 2 * mid + p;
      lap = scale_q16(dxx, inv_dx_q) + scale_q16(dyy, inv_dy_q);
      res = middle_rhs[c] - lap;
      m = res < 0 ? -res : res;
      if (m >= 64'd1 << 40) begin
        sat_flag = 1'b1;
        sq = AllOnes;
      end else begin
        sq = ((m[39:20] * m[39:20]) << 24) + ((m[39:20] * m[19:0]) << 5)
           + ((m[19:0] * m[19:0]) >> 16);
      end
      if (sq > AllOnes - square_sum) begin
        square_sum = AllOnes;
        sat_flag = 1'b1;
      end else begin
        square_sum += sq;
      end
    end
    upper_row[c] = mid;
    middle_row[c] = p;
    middle_rhs[c] = q;
    left_mid = mid;
    if (c + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt + 1 >= h) begin
        n = (w - 2) * (h - 2);
        mean = square_sum / n;
        ovf = sat_flag;
        if (mean > OutMax) begin
          mean = OutMax;
          ovf = 1'b1;
        end
        gr.mean = mean[OutW-1:0];
        gr.ovf = ovf;
        grid_results.push_back(gr);
        square_sum = 0;
        sat_flag = 1'b0;
        row_cnt = 0;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt = c + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grid_result_t gr;
    if (!rst_ni) begin
      width_q = GridWidthRst;
      height_q = GridHeightRst;
      inv_dx_q = InvSqRst;
      inv_dy_q = InvSqRst;
      for (int i = 0; i < RowCells; i++) begin
        upper_row[i] = 0;
        middle_row[i] = 0;
        middle_rhs[i] = 0;
      end
      left_mid = 0;
      square_sum = 0;
      col_cnt = 0;
      row_cnt = 0;
      sat_flag = 1'b0;
      fail_count_o = 0;
      grid_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CfgGridWidth: width_q = cfg_data_i[10:0];
          CfgGridHeight: height_q = cfg_data_i[15:0];
          CfgInvDxSquared: inv_dx_q = cfg_data_i;
          CfgInvDySquared: inv_dy_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) add_cell(pressure_value_i, rhs_value_i);
      if (out_valid_i && !out_stall_i) begin
        if (grid_results.size() == 0) begin
          $display("%0t: unexpected result mean=%h ovf=%b", $time,
                   mean_square_residual_i, overflow_seen_i);
          fail_count_o++;
        end else begin
          gr = grid_results.pop_front();
          if (gr.mean !== mean_square_residual_i) begin
            $display("%0t: mean mismatch expected %h actual %h", $time, gr.mean,
                     mean_square_residual_i);
            fail_count_o++;
          end
          if (gr.ovf !== overflow_seen_i) begin
            $display("%0t: overflow mismatch expected %b actual %b", $time, gr.ovf,
                     overflow_seen_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_laplace_residual_mean_square.sv */
// tb_laplace_residual_mean_square: streams grids of random and extreme cells through
// the block under several grid settings; depends on lrms_pkg, lrms_checker and the rtl
`timescale 1ns / 1ps
`default_nettype none

module tb_laplace_residual_mean_square;
  import lrms_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk, rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [31:0] pressure, rhs;
  logic out_valid, out_stall;
  logic [OutW-1:0] mean_sq;
  logic ovf;
  int fail_count, pending;
  int cells_sent;
  int idle_cycles;
  bit calm, hold_off;
  int mode;

  laplace_residual_mean_square dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pressure_value_i(pressure), .rhs_value_i(rhs), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .mean_square_residual_o(mean_sq), .overflow_seen_o(ovf)
  );

  lrms_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .pressure_value_i(pressure), .rhs_value_i(rhs), .out_valid_i(out_valid),
    .out_stall_i(out_stall), .mean_square_residual_i(mean_sq), .overflow_seen_i(ovf),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] cell_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $urandom();
      default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    endcase
  endfunction

  // one cell transfer, with random idle before it unless calm
  task automatic send_cell(logic [31:0] p, logic [31:0] q);
    if (!calm) begin
      while ($urandom_range(0, 99) < 38) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    pressure <= p;
    rhs <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cells_sent++;
  endtask

  task automatic send_grid(int w, int h, int style);
    for (int i = 0; i < w * h; i++) begin
      case (style)
        0: send_cell(cell_value(), cell_value());
        1: send_cell(32'h7FFF_FFFF, 32'h8000_0000);
        2: send_cell(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, i[1] ? 32'hFFFF_FFFF : 32'h0);
        default: send_cell(32'h0, 32'h0);
      endcase
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every grid result is out, then let the divider settle
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic configure(int w, int h, logic [31:0] dx, logic [31:0] dy);
    write_reg(CfgGridWidth, w);
    write_reg(CfgGridHeight, h);
    write_reg(CfgInvDxSquared, dx);
    write_reg(CfgInvDySquared, dy);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall, a long hold-off when asked
  initial begin
    out_stall = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 38);
    end
  end

  initial begin
    int w, h, sel;
    cfg_we = 1'b0;
    cfg_index = CfgGridWidth;
    cfg_data = '0;
    in_valid = 1'b0;
    pressure = '0;
    rhs = '0;
    calm = 1'b0;
    hold_off = 1'b0;
    cells_sent = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset settings, then extremes of fields and factors
    send_grid(3, 3, 1);
    send_grid(3, 3, 2);
    drain();
    configure(3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_grid(3, 3, 1);
    send_grid(3, 3, 3);
    drain();
    configure(4, 3, 32'h0, 32'h0);
    send_grid(4, 3, 2);
    drain();
    // out of range width and height get clamped
    configure(2, 0, 32'h0001_0000, 32'h0000_4000);
    send_grid(3, 3, 0);
    drain();
    // wide row
    configure(300, 3, 32'h0000_0100, 32'h0002_0000);
    send_grid(300, 3, 0);
    drain();
    // results held off while grids keep streaming in
    configure(3, 3, 32'h0001_0000, 32'h0001_0000);
    hold_off = 1'b1;
    for (int g = 0; g < 4; g++) send_grid(3, 3, 0);
    drain();
    mode = 0;
    while (cells_sent < 1900) begin
      calm = (mode == 3);
      w = $urandom_range(3, 8);
      h = $urandom_range(3, 6);
      sel = $urandom_range(0, 3);
      configure(w, h, sel == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 32'h0004_0000),
                sel == 1 ? 32'h0 : $urandom_range(0, 32'h0004_0000));
      for (int g = 0; g < 3; g++) send_grid(w, h, $urandom_range(0, 9) == 0 ? 2 : 0);
      drain();
      mode = (mode + 1) % 6;
    end
    calm = 1'b0;
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
